@@ src/assert_macros.svh @@
// Assertion macros for the checker of this project.
// Depends on nothing; included by the checker module kdbt_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

@@ src/kdbt_pkg.sv @@
// Package for the keyed dense box table: sizes, codes and the sequencer state type.
// Depends on nothing; used by the top level, the checker and the testbench.
`default_nettype none
package kdbt_pkg;
  localparam int unsigned SLOTS_DEF   = 1024;
  localparam int unsigned BUCKETS_DEF = 2048;
  localparam logic [31:0] HASH_MUL    = 32'd2654435769;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_WALK,
    S_WALK_CHK,
    S_DECIDE,
    S_ADD_POP,
    S_ADD_LINK,
    S_UPD,
    S_RM_SLOT,
    S_RM_LAST,
    S_RM_HASH,
    S_RM_HEAD,
    S_RM_WALK,
    S_RM_CHK,
    S_RM_MOVE,
    S_RM_UNLINK,
    S_OUT
  } state_t;

  function automatic logic [31:0] hash_of(input logic [31:0] key);
    hash_of = key * HASH_MUL;
  endfunction
endpackage
`default_nettype wire

@@ src/keyed_dense_box_table.sv @@
// Keyed dense box table: one transaction at a time. Each operation walks the key's hash chain
// in the chain memories, addressing each node visited in S_WALK and comparing its registered
// read in S_WALK_CHK; remove walks a second chain for the moved key and then rewrites slot and
// chain entries. The result register holds the answer until taken, and the next transaction is
// accepted from the cycle after that. After reset a clearing pass writes every bucket head and
// every free-stack entry, during which no transaction is accepted.
// Depends on kdbt_pkg and kdbt_mem.
`default_nettype none
module keyed_dense_box_table #(
  parameter int unsigned SLOTS   = kdbt_pkg::SLOTS_DEF,
  parameter int unsigned BUCKETS = kdbt_pkg::BUCKETS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_lower_x,
  input  wire logic [31:0] in_lower_y,
  input  wire logic [31:0] in_upper_x,
  input  wire logic [31:0] in_upper_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [9:0]       out_slot,
  output logic [10:0]      out_entry_count
);
  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned NW = SW + 1;
  localparam int unsigned CW = (BW > SW) ? BW : SW;
  localparam logic [NW-1:0] NIL = NW'(SLOTS);

  // Which chain search is running, and which tail the shared unlink state performs.
  localparam logic [2:0] SUB_FIND  = 3'd0;
  localparam logic [2:0] SUB_ADD   = 3'd1;
  localparam logic [2:0] SUB_MOVED = 3'd2;

  kdbt_pkg::state_t state_r, state_nxt;

  logic [CW:0]    clr_r, clr_nxt;
  logic [1:0]     mode_r, mode_nxt;
  logic [31:0]    key_r, key_nxt;
  logic [63:0]    lower_r, lower_nxt, upper_r, upper_nxt;
  logic [BW-1:0]  bkt_r, bkt_nxt;
  logic [NW-1:0]  node_r, node_nxt, prev_r, prev_nxt;
  logic [NW-1:0]  found_r, found_nxt, fprev_r, fprev_nxt;
  logic [NW-1:0]  steps_r, steps_nxt;
  logic [NW-1:0]  live_r, live_nxt, top_r, top_nxt;
  logic [SW-1:0]  slot_r, slot_nxt, last_r, last_nxt;
  logic [31:0]    mkey_r, mkey_nxt;
  logic [NW-1:0]  rnext_r, rnext_nxt;
  logic [1:0]     ost_r, ost_nxt;
  logic [SW-1:0]  oslot_r, oslot_nxt;
  logic [NW-1:0]  ocnt_r, ocnt_nxt;
  logic           ov_r, ov_nxt;
  logic [2:0]     sub_r, sub_nxt;
  // The removed node and its predecessor survive the second search here.
  logic [NW-1:0]  rnode_r, rprev_r;
  logic [31:0]    hash_key, hash_mkey;

  // Memory ports.
  logic bh_we, ck_we, cs_we, cn_we, fl_we, sk_we, sb_we;
  logic [BW-1:0] bh_a;
  logic [SW-1:0] ck_a, fl_a, sk_a;
  logic [NW-1:0] bh_wd, bh_rd, cn_wd, cn_rd;
  logic [SW-1:0] cs_wd, cs_rd, fl_wd, fl_rd;
  logic [31:0]   ck_rd, sk_wd, sk_rd;
  logic [127:0]  sb_wd, sb_rd;

  kdbt_mem #(.DEPTH(BUCKETS), .WIDTH(NW)) u_head (
    .clk(clk), .we(bh_we), .addr(bh_a), .wdata(bh_wd), .rdata(bh_rd));
  kdbt_mem #(.DEPTH(SLOTS), .WIDTH(32)) u_ckey (
    .clk(clk), .we(ck_we), .addr(ck_a), .wdata(key_r), .rdata(ck_rd));
  kdbt_mem #(.DEPTH(SLOTS), .WIDTH(SW)) u_cslot (
    .clk(clk), .we(cs_we), .addr(ck_a), .wdata(cs_wd), .rdata(cs_rd));
  kdbt_mem #(.DEPTH(SLOTS), .WIDTH(NW)) u_cnext (
    .clk(clk), .we(cn_we), .addr(ck_a), .wdata(cn_wd), .rdata(cn_rd));
  kdbt_mem #(.DEPTH(SLOTS), .WIDTH(SW)) u_free (
    .clk(clk), .we(fl_we), .addr(fl_a), .wdata(fl_wd), .rdata(fl_rd));
  kdbt_mem #(.DEPTH(SLOTS), .WIDTH(32)) u_skey (
    .clk(clk), .we(sk_we), .addr(sk_a), .wdata(sk_wd), .rdata(sk_rd));
  kdbt_mem #(.DEPTH(SLOTS), .WIDTH(128)) u_sbox (
    .clk(clk), .we(sb_we), .addr(sk_a), .wdata(sb_wd), .rdata(sb_rd));

  assign hash_key  = kdbt_pkg::hash_of(key_r);
  assign hash_mkey = kdbt_pkg::hash_of(mkey_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kdbt_pkg::S_CLEAR;
      clr_r   <= '0;
      live_r  <= '0;
      top_r   <= NIL;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      live_r  <= live_nxt;
      top_r   <= top_nxt;
      ov_r    <= ov_nxt;
    end
    mode_r <= mode_nxt;  key_r <= key_nxt;  lower_r <= lower_nxt;  upper_r <= upper_nxt;
    bkt_r <= bkt_nxt;    node_r <= node_nxt; prev_r <= prev_nxt;
    found_r <= found_nxt; fprev_r <= fprev_nxt; steps_r <= steps_nxt;
    slot_r <= slot_nxt;  last_r <= last_nxt; mkey_r <= mkey_nxt; rnext_r <= rnext_nxt;
    ost_r <= ost_nxt;    oslot_r <= oslot_nxt; ocnt_r <= ocnt_nxt; sub_r <= sub_nxt;
  end

  assign in_ready        = (state_r == kdbt_pkg::S_IDLE) && !ov_r;
  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_slot        = 10'(oslot_r);
  assign out_entry_count = 11'(ocnt_r);

  always_comb begin
    state_nxt = state_r;  clr_nxt = clr_r;  mode_nxt = mode_r;  key_nxt = key_r;
    lower_nxt = lower_r;  upper_nxt = upper_r;  bkt_nxt = bkt_r;  node_nxt = node_r;
    prev_nxt = prev_r;  found_nxt = found_r;  fprev_nxt = fprev_r;  steps_nxt = steps_r;
    live_nxt = live_r;  top_nxt = top_r;  slot_nxt = slot_r;  last_nxt = last_r;
    mkey_nxt = mkey_r;  rnext_nxt = rnext_r;  ost_nxt = ost_r;  oslot_nxt = oslot_r;
    ocnt_nxt = ocnt_r;  ov_nxt = ov_r;  sub_nxt = sub_r;
    bh_we = 1'b0;  bh_a = bkt_r;  bh_wd = NIL;
    ck_we = 1'b0;  cs_we = 1'b0;  cn_we = 1'b0;  ck_a = node_r[SW-1:0];
    cs_wd = slot_r;  cn_wd = NIL;
    fl_we = 1'b0;  fl_a = '0;  fl_wd = '0;
    sk_we = 1'b0;  sb_we = 1'b0;  sk_a = slot_r;  sk_wd = key_r;
    sb_wd = {upper_r, lower_r};

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      kdbt_pkg::S_CLEAR: begin
        bh_a = clr_r[BW-1:0];
        bh_we = (clr_r < (CW+1)'(BUCKETS));
        fl_a = clr_r[SW-1:0];
        fl_wd = clr_r[SW-1:0];
        fl_we = (clr_r < (CW+1)'(SLOTS));
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (CW+1)'((BUCKETS > SLOTS ? BUCKETS : SLOTS) - 1)) begin
          state_nxt = kdbt_pkg::S_IDLE;
        end
      end
      kdbt_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          mode_nxt  = in_mode;
          key_nxt   = in_key;
          lower_nxt = {in_lower_y, in_lower_x};
          upper_nxt = {in_upper_y, in_upper_x};
          sub_nxt   = SUB_FIND;
          state_nxt = kdbt_pkg::S_HASH;
        end
      end
      // Shared chain search: key_r is the key sought, sub_r tells which search runs.
      kdbt_pkg::S_HASH: begin
        bkt_nxt = hash_key[BW-1:0];
        state_nxt = kdbt_pkg::S_HEAD;
      end
      kdbt_pkg::S_HEAD: begin
        state_nxt = kdbt_pkg::S_WALK;
        prev_nxt = NIL;
        steps_nxt = '0;
      end
      kdbt_pkg::S_WALK: begin
        // bh_rd holds the head on first entry; later the node comes from cn_rd.
        if (steps_r == '0) begin
          node_nxt = bh_rd;
        end else begin
          node_nxt = cn_rd;
        end
        // Address the node now so that its chain entries are on the read ports next cycle.
        ck_a = node_nxt[SW-1:0];
        state_nxt = kdbt_pkg::S_WALK_CHK;
        if (node_nxt >= NIL || steps_r >= NIL) begin
          found_nxt = NIL;
          fprev_nxt = prev_r;
          state_nxt = (sub_r == SUB_FIND) ? kdbt_pkg::S_DECIDE : kdbt_pkg::S_RM_MOVE;
        end
      end
      kdbt_pkg::S_WALK_CHK: begin
        // Chain key, slot and next of node_r are now on the read ports.
        if (ck_rd == key_r) begin
          found_nxt = node_r;
          fprev_nxt = prev_r;
          rnext_nxt = (sub_r == SUB_FIND) ? cn_rd : rnext_r;
          slot_nxt  = (sub_r == SUB_FIND) ? cs_rd : slot_r;
          state_nxt = (sub_r == SUB_FIND) ? kdbt_pkg::S_DECIDE : kdbt_pkg::S_RM_MOVE;
        end else begin
          prev_nxt = node_r;
          steps_nxt = steps_r + 1'b1;
          state_nxt = kdbt_pkg::S_WALK;
        end
      end
      kdbt_pkg::S_DECIDE: begin
        ost_nxt = kdbt_pkg::ST_NOT_FOUND;
        oslot_nxt = '0;
        ocnt_nxt = live_r;
        state_nxt = kdbt_pkg::S_OUT;
        case (kdbt_pkg::mode_t'(mode_r))
          kdbt_pkg::MODE_ADD: begin
            if (found_r != NIL) begin
              ost_nxt = kdbt_pkg::ST_PRESENT;
            end else if (live_r >= NIL || top_r == '0) begin
              ost_nxt = kdbt_pkg::ST_FULL;
            end else begin
              fl_a = SW'(top_r - 1'b1);
              top_nxt = top_r - 1'b1;
              slot_nxt = SW'(live_r);
              state_nxt = kdbt_pkg::S_ADD_POP;
            end
          end
          kdbt_pkg::MODE_UPDATE: begin
            if (found_r != NIL) begin
              state_nxt = kdbt_pkg::S_UPD;
            end
          end
          kdbt_pkg::MODE_REMOVE: begin
            if (found_r != NIL && live_r != '0) begin
              node_nxt = found_r;
              prev_nxt = fprev_r;
              live_nxt = live_r - 1'b1;
              last_nxt = SW'(live_r - 1'b1);
              state_nxt = kdbt_pkg::S_RM_SLOT;
            end
          end
          default: begin
          end
        endcase
      end
      kdbt_pkg::S_ADD_POP: begin
        // New node index is on the free-stack read port; write slot entry meanwhile.
        sk_we = 1'b1;
        sb_we = 1'b1;
        live_nxt = live_r + 1'b1;
        node_nxt = {1'b0, fl_rd};
        state_nxt = kdbt_pkg::S_ADD_LINK;
      end
      kdbt_pkg::S_ADD_LINK: begin
        ck_we = 1'b1;
        cs_we = 1'b1;
        cn_we = 1'b1;
        cn_wd = NIL;
        sub_nxt = SUB_ADD;
        state_nxt = kdbt_pkg::S_RM_UNLINK;
      end
      kdbt_pkg::S_UPD: begin
        sb_we = 1'b1;
        ost_nxt = kdbt_pkg::ST_DONE;
        oslot_nxt = slot_r;
        state_nxt = kdbt_pkg::S_OUT;
      end
      kdbt_pkg::S_RM_SLOT: begin
        // Read the last slot's key and box.
        sk_a = last_r;
        state_nxt = kdbt_pkg::S_RM_LAST;
      end
      kdbt_pkg::S_RM_LAST: begin
        mkey_nxt = sk_rd;
        lower_nxt = sb_rd[63:0];
        upper_nxt = sb_rd[127:64];
        fprev_nxt = prev_r;
        found_nxt = node_r;
        state_nxt = kdbt_pkg::S_RM_HASH;
      end
      kdbt_pkg::S_RM_HASH: begin
        // Second search for the moved key; the removed node's data is parked.
        bkt_nxt = hash_mkey[BW-1:0];
        key_nxt = mkey_r;
        mkey_nxt = key_r;
        node_nxt = {found_r};
        rnext_nxt = rnext_r;
        sub_nxt = SUB_MOVED;
        state_nxt = kdbt_pkg::S_RM_HEAD;
      end
      kdbt_pkg::S_RM_HEAD: begin
        // Start the walk of the moved key's chain; removed node and prev are saved in rnode_r and rprev_r.
        prev_nxt = NIL;
        steps_nxt = '0;
        node_nxt = node_r;
        state_nxt = kdbt_pkg::S_WALK;
      end
      kdbt_pkg::S_RM_MOVE: begin
        // found_r is the moved key's node; write moved slot data and repoint.
        sk_wd = key_r;
        sk_we = 1'b1;
        sb_we = 1'b1;
        if (found_r != NIL) begin
          ck_a = found_r[SW-1:0];
          cs_we = 1'b1;
          cs_wd = slot_r;
        end
        key_nxt = mkey_r;
        state_nxt = kdbt_pkg::S_RM_CHK;
      end
      kdbt_pkg::S_RM_CHK: begin
        // Recompute the removed key's bucket for the unlink.
        bkt_nxt = hash_key[BW-1:0];
        state_nxt = kdbt_pkg::S_RM_UNLINK;
      end
      kdbt_pkg::S_RM_UNLINK: begin
        // Shared tail: link node_r behind fprev_r (add) or unlink removed node (remove).
        if (sub_r == SUB_ADD) begin
          if (fprev_r == NIL) begin
            bh_a = hash_key[BW-1:0];
            bh_we = 1'b1;
            bh_wd = node_r;
          end else begin
            ck_a = fprev_r[SW-1:0];
            cn_we = 1'b1;
            cn_wd = node_r;
          end
          ost_nxt = kdbt_pkg::ST_DONE;
          oslot_nxt = slot_r;
          ocnt_nxt = live_r;
        end else begin
          if (rprev_r == NIL) begin
            bh_we = 1'b1;
            bh_wd = rnext_r;
          end else begin
            ck_a = rprev_r[SW-1:0];
            cn_we = 1'b1;
            cn_wd = rnext_r;
          end
          if (top_r < NIL) begin
            fl_a = SW'(top_r);
            fl_we = 1'b1;
            fl_wd = rnode_r[SW-1:0];
            top_nxt = top_r + 1'b1;
          end
          ost_nxt = kdbt_pkg::ST_DONE;
          oslot_nxt = slot_r;
          ocnt_nxt = live_r;
        end
        state_nxt = kdbt_pkg::S_OUT;
      end
      kdbt_pkg::S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          state_nxt = kdbt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kdbt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == kdbt_pkg::S_RM_LAST) begin
      rnode_r <= node_r;
      rprev_r <= prev_r;
    end
  end
endmodule
`default_nettype wire

@@ src/kdbt_mem.sv @@
// Generic single-port synchronous RAM with registered read.
// Depends on nothing; instantiated by the keyed dense box table top level.
`default_nettype none
module kdbt_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ src/kdbt_checker.sv @@
// Port-level checker for the keyed dense box table, bound to the top level.
// Depends on assert_macros.svh and kdbt_pkg.
`include "assert_macros.svh"
`default_nettype none
module kdbt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [9:0]  out_slot,
  input wire logic [10:0] out_entry_count
);
  `CHK_IMPLY(a_slot_zero, clk, rst_n, out_valid && out_status != kdbt_pkg::ST_DONE, out_slot == '0, "slot set")
  `CHK_IMPLY(a_one_busy, clk, rst_n, out_valid, !in_ready, "input taken while result pending")
  `CHK_NEXT(a_busy_after, clk, rst_n, in_valid && in_ready, !in_ready, "second transaction at once")
  `CHK_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_entry_count), "result dropped")
endmodule
bind keyed_dense_box_table kdbt_checker u_chk (.*);
`default_nettype wire

@@ tb/keyed_dense_box_table_tb.sv @@
// Testbench for the keyed dense box table: drives add, update, remove and no-op transactions and
// checks every result against a behavioural hash map with a dense slot array kept here.
// Depends on kdbt_pkg and keyed_dense_box_table.
`default_nettype none
module keyed_dense_box_table_tb;
  localparam int NSLOT = 1024;
  localparam int NBUCK = 2048;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int DRAIN_TO = 700;

  typedef struct packed {
    kdbt_pkg::status_t status;
    logic [9:0]        slot;
    logic [10:0]       count;
  } answer_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [1:0]  in_mode;
  logic [31:0] in_key, in_lower_x, in_lower_y, in_upper_x, in_upper_y;
  logic [1:0]  out_status;
  logic [9:0]  out_slot;
  logic [10:0] out_entry_count;

  keyed_dense_box_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode), .in_key(in_key),
    .in_lower_x(in_lower_x), .in_lower_y(in_lower_y),
    .in_upper_x(in_upper_x), .in_upper_y(in_upper_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_slot(out_slot), .out_entry_count(out_entry_count)
  );

  // Model state.
  logic [10:0] head_of_bucket [NBUCK];
  logic [31:0] node_key [NSLOT];
  logic [9:0]  node_slot [NSLOT];
  logic [10:0] node_next [NSLOT];
  logic [9:0]  spare_nodes [NSLOT];
  int unsigned spare_top;
  logic [31:0] dense_key [NSLOT];
  logic [63:0] dense_lower [NSLOT];
  logic [63:0] dense_upper [NSLOT];
  int unsigned live;

  answer_t     pending_answers[$];
  logic [31:0] known_keys[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          sent = 0;
  int          taken = 0;
  bit          hold_receiver = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [10:0] bucket_of_key(logic [31:0] key);
    logic [31:0] h;
    h = key * 32'd2654435769;
    return h[10:0];
  endfunction

  // Returns the node holding the key or NSLOT; prev gets the node before it or the tail.
  function automatic int lookup_node(logic [31:0] key, output int prev);
    int n, steps;
    n = head_of_bucket[bucket_of_key(key)];
    prev = NSLOT;
    steps = 0;
    while (n < NSLOT && steps < NSLOT) begin
      if (node_key[n] == key) break;
      prev = n;
      n = node_next[n];
      steps++;
    end
    if (n >= NSLOT || steps >= NSLOT) n = NSLOT;
    return n;
  endfunction

  function automatic answer_t apply_operation(logic [1:0] mode, logic [31:0] key,
                                              logic [63:0] lower, logic [63:0] upper);
    answer_t a;
    int prev, node, nn, last, mprev, moved, slot;
    a.status = kdbt_pkg::ST_NOT_FOUND;
    slot = 0;
    node = lookup_node(key, prev);
    if (mode == kdbt_pkg::MODE_ADD) begin
      if (node != NSLOT) a.status = kdbt_pkg::ST_PRESENT;
      else if (live >= NSLOT || spare_top == 0) a.status = kdbt_pkg::ST_FULL;
      else begin
        slot = live;
        live++;
        dense_key[slot] = key;
        dense_lower[slot] = lower;
        dense_upper[slot] = upper;
        spare_top--;
        nn = spare_nodes[spare_top];
        node_key[nn] = key;
        node_slot[nn] = slot[9:0];
        node_next[nn] = 11'(NSLOT);
        if (prev == NSLOT) head_of_bucket[bucket_of_key(key)] = nn[10:0];
        else node_next[prev] = nn[10:0];
        a.status = kdbt_pkg::ST_DONE;
      end
    end else if (mode == kdbt_pkg::MODE_UPDATE) begin
      if (node != NSLOT) begin
        slot = node_slot[node];
        dense_lower[slot] = lower;
        dense_upper[slot] = upper;
        a.status = kdbt_pkg::ST_DONE;
      end
    end else if (mode == kdbt_pkg::MODE_REMOVE) begin
      if (node != NSLOT && live > 0) begin
        live--;
        last = live;
        slot = node_slot[node];
        moved = lookup_node(dense_key[last], mprev);
        dense_key[slot] = dense_key[last];
        dense_lower[slot] = dense_lower[last];
        dense_upper[slot] = dense_upper[last];
        if (moved != NSLOT) node_slot[moved] = slot[9:0];
        if (prev == NSLOT) head_of_bucket[bucket_of_key(key)] = node_next[node];
        else node_next[prev] = node_next[node];
        if (spare_top < NSLOT) begin
          spare_nodes[spare_top] = node[9:0];
          spare_top++;
        end
        a.status = kdbt_pkg::ST_DONE;
      end
    end
    a.slot = (a.status == kdbt_pkg::ST_DONE) ? slot[9:0] : 10'd0;
    a.count = live[10:0];
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one transaction and records the expected answer at acceptance.
  // Valid drops between transactions.
  task automatic send_op(logic [1:0] mode, logic [31:0] key, logic [31:0] lx,
                         logic [31:0] ly, logic [31:0] ux, logic [31:0] uy, bit gaps = 1);
    int g;
    g = gaps ? pick_gap() : 0;
    repeat (g + 1) @(posedge clk);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_key <= key;
    in_lower_x <= lx;
    in_lower_y <= ly;
    in_upper_x <= ux;
    in_upper_y <= uy;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(apply_operation(mode, key, {ly, lx}, {uy, ux}));
    sent++;
    if (mode == kdbt_pkg::MODE_ADD) known_keys.push_back(key);
    in_valid <= 1'b0;
  endtask

  task automatic send_rand_box(logic [1:0] mode, logic [31:0] key);
    send_op(mode, key, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic logic [31:0] some_key();
    if (known_keys.size() == 0 || $urandom_range(0, 9) == 0) return $urandom;
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // Receiver: random stalls, or a long hold when requested.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_receiver) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 99) < 50);
  end

  always @(posedge clk) begin
    answer_t exp_a;
    if (rst_n && out_valid && out_ready) begin
      taken++;
      if (pending_answers.size() == 0) begin
        $error("result with nothing expected: status %0d slot %0d count %0d",
               out_status, out_slot, out_entry_count);
        errors++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (out_status !== exp_a.status) begin
          $error("status: expected %0d, got %0d", exp_a.status, out_status);
          errors++;
        end
        if (out_slot !== exp_a.slot) begin
          $error("slot: expected %0d, got %0d", exp_a.slot, out_slot);
          errors++;
        end
        if (out_entry_count !== exp_a.count) begin
          $error("entry_count: expected %0d, got %0d", exp_a.count, out_entry_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("keyed_dense_box_table test failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_op(kdbt_pkg::MODE_REMOVE, 32'h0, 0, 0, 0, 0);
    send_op(kdbt_pkg::MODE_UPDATE, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_op(kdbt_pkg::MODE_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_op(kdbt_pkg::MODE_ADD, 32'hFFFF_FFFF, '1, '1, '1, '1);
    send_op(kdbt_pkg::MODE_ADD, 32'h0, 1, 2, 3, 4);
    send_op(kdbt_pkg::MODE_UPDATE, 32'h0, '1, 32'h5555_5555, 32'hAAAA_AAAA, 0);
    send_op(kdbt_pkg::MODE_NONE, 32'h0, 0, 0, 0, 0);
    // Keys 2048 apart share a bucket, so these build and then cut into one chain.
    send_op(kdbt_pkg::MODE_ADD, 32'd2048, 5, 6, 7, 8);
    send_op(kdbt_pkg::MODE_ADD, 32'd4096, 5, 6, 7, 8);
    send_op(kdbt_pkg::MODE_ADD, 32'd6144, 5, 6, 7, 8);
    send_op(kdbt_pkg::MODE_REMOVE, 32'd4096, 0, 0, 0, 0);
    send_op(kdbt_pkg::MODE_UPDATE, 32'd6144, 9, 9, 9, 9);
    send_op(kdbt_pkg::MODE_REMOVE, 32'h0, 0, 0, 0, 0);
    send_op(kdbt_pkg::MODE_REMOVE, 32'd6144, 0, 0, 0, 0);
    send_op(kdbt_pkg::MODE_REMOVE, 32'd6144, 0, 0, 0, 0);
    send_op(kdbt_pkg::MODE_UPDATE, 32'd2048, 1, 1, 1, 1);
    send_op(kdbt_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_op(kdbt_pkg::MODE_REMOVE, 32'd2048, 0, 0, 0, 0);
  endtask

  task automatic test_random_mix(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_rand_box(kdbt_pkg::MODE_ADD, ($urandom_range(0, 3) == 0) ? some_key() : $urandom);
      end else if (r < 70) send_rand_box(kdbt_pkg::MODE_UPDATE, some_key());
      else if (r < 97) send_rand_box(kdbt_pkg::MODE_REMOVE, some_key());
      else send_rand_box(kdbt_pkg::MODE_NONE, some_key());
    end
  endtask

  // Fill the table to its limit, try beyond it, then drain part of it, mostly by removes.
  task automatic test_fill_and_drain();
    while (live < NSLOT) send_rand_box(kdbt_pkg::MODE_ADD, $urandom);
    send_rand_box(kdbt_pkg::MODE_ADD, $urandom);
    send_rand_box(kdbt_pkg::MODE_ADD, dense_key[0]);
    send_rand_box(kdbt_pkg::MODE_REMOVE, dense_key[NSLOT - 1]);
    send_rand_box(kdbt_pkg::MODE_ADD, $urandom);
    repeat (30) send_rand_box(kdbt_pkg::MODE_UPDATE, dense_key[$urandom_range(0, live - 1)]);
    while (live > DRAIN_TO) begin
      if ($urandom_range(0, 9) < 9) begin
        send_rand_box(kdbt_pkg::MODE_REMOVE, dense_key[$urandom_range(0, live - 1)]);
      end else send_rand_box(kdbt_pkg::MODE_ADD, $urandom);
    end
  endtask

  // The receiver holds off while the sender keeps offering transactions.
  task automatic test_backpressure();
    hold_receiver = 1;
    fork
      repeat (300) @(posedge clk);
      repeat (20) begin
        send_op(kdbt_pkg::MODE_ADD, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
      end
    join_any
    repeat (300) @(posedge clk);
    hold_receiver = 0;
    wait fork;
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = kdbt_pkg::MODE_ADD;
    in_key = '0;
    in_lower_x = '0;
    in_lower_y = '0;
    in_upper_x = '0;
    in_upper_y = '0;
    for (i = 0; i < NBUCK; i++) head_of_bucket[i] = 11'(NSLOT);
    for (i = 0; i < NSLOT; i++) spare_nodes[i] = i[9:0];
    spare_top = NSLOT;
    live = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix(150);
    test_backpressure();
    test_fill_and_drain();
    test_random_mix(60);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d transactions, %0d results checked, including a full table,", sent, taken);
    $display("chain removals, missing keys, duplicates and a long output stall.");
    if (errors == 0 && pending_answers.size() == 0) $display("keyed_dense_box_table test passed");
    else $display("keyed_dense_box_table test failed");
    $finish;
  end
endmodule
`default_nettype wire
